[hdl/rit_pkg.sv]
// Shared types and constants for the repeating interval timer.
package rit_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned STATE_W = 2;
	localparam int unsigned CFG_W   = 1;

	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_CHECK      = 3'd0,
		REQ_START      = 3'd1,
		REQ_STOP       = 3'd2,
		REQ_RESET      = 3'd3,
		REQ_SET_TARGET = 3'd4
	} req_code_t;

	typedef enum logic [STATE_W-1:0] {
		ST_STOPPED = 2'd0,
		ST_RUNNING = 2'd1,
		ST_EXPIRED = 2'd2
	} run_state_t;

	typedef enum logic [CFG_W-1:0] {
		CFG_INTERVAL = 1'b0,
		CFG_REPEATS  = 1'b1
	} cfg_index_t;

endpackage

[hdl/rit_if.sv]
// Request, result and configuration channel interfaces.
interface rit_req_if;
	logic                       valid;
	logic                       ready;
	logic [rit_pkg::REQ_W-1:0]  req_type;
	rit_pkg::time_t             now;
	rit_pkg::time_t             time_value;

	modport source (output valid, req_type, now, time_value, input ready);
	modport sink   (input valid, req_type, now, time_value, output ready);
endinterface

interface rit_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        fired;
	logic [rit_pkg::STATE_W-1:0] timer_state;
	rit_pkg::time_t              time_left;
	rit_pkg::time_t              repeats_left;
	rit_pkg::time_t              target_time;

	modport source (output valid, fired, timer_state, time_left, repeats_left, target_time,
		input ready);
	modport sink   (input valid, fired, timer_state, time_left, repeats_left, target_time,
		output ready);
endinterface

interface rit_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rit_pkg::CFG_W-1:0] index;
	rit_pkg::time_t            data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/repeating_interval_timer.sv]
// Repeating interval timer: top level.
//
//  channel | dir | fields
//  cfg     | in  | index (0 interval, 1 repeats), data
//  req     | in  | req_type, now, time_value
//  rsp     | out | fired, timer_state, time_left, repeats_left, target_time
//
// One request per cycle sustained while results are taken; a taken request is captured in the
// input register and then moves on to the result register, where it is presented as the result.
// The result register decouples the sides: req.ready drops only while both stages are full
// and rsp.ready is low. cfg is always ready.
// arst_n clears the timer state, the configuration registers and both stage valids.
module repeating_interval_timer (
	input  logic       clk,
	input  logic       arst_n,
	rit_cfg_if.sink    cfg,
	rit_req_if.sink    req,
	rit_rsp_if.source  rsp
);
	import rit_pkg::*;

	logic       valid_s1;
	req_code_t  req_type_s1;
	time_t      now_s1;
	time_t      time_value_s1;

	time_t      interval_q;
	time_t      repeats_q;
	run_state_t run_state_q;
	time_t      target_q;
	time_t      saved_q;
	time_t      rep_left_q;

	logic       rsp_valid_q;
	logic       fired_q;
	run_state_t state_out_q;
	time_t      time_left_q;
	time_t      rep_out_q;
	time_t      target_out_q;

	logic       advance;
	logic       step;
	logic       fired_d;
	run_state_t state_d;
	time_t      target_d;
	time_t      saved_d;
	time_t      rep_left_d;
	time_t      time_left_d;
	time_t      rep_out_d;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1   <= req_code_t'(req.req_type);
			now_s1        <= req.now;
			time_value_s1 <= req.time_value;
		end
	end

	always_comb begin
		fired_d    = 1'b0;
		state_d    = run_state_q;
		target_d   = target_q;
		saved_d    = saved_q;
		rep_left_d = rep_left_q;
		unique case (req_type_s1)
			REQ_CHECK: begin
				if (run_state_q == ST_RUNNING && now_s1 >= target_q) begin
					fired_d = 1'b1;
					if (rep_left_q != time_t'(1)) begin
						// zero repeats means forever: counter stays at zero
						if (rep_left_q != '0)
							rep_left_d = rep_left_q - time_t'(1);
						target_d = target_q + interval_q;
					end else begin
						state_d = ST_EXPIRED;
					end
				end
			end
			REQ_START: begin
				state_d = ST_RUNNING;
				if (saved_q != '0) begin
					target_d = time_value_s1 + saved_q;
					saved_d  = '0;
				end else begin
					target_d = time_value_s1 + interval_q;
				end
			end
			REQ_STOP: begin
				state_d = ST_STOPPED;
				if (now_s1 < target_q)
					saved_d = target_q - now_s1;
			end
			REQ_RESET: begin
				state_d    = ST_STOPPED;
				saved_d    = '0;
				rep_left_d = repeats_q;
			end
			REQ_SET_TARGET: begin
				target_d = time_value_s1;
			end
			default: begin
			end
		endcase

		time_left_d = (state_d == ST_RUNNING) ? (target_d - now_s1) : saved_d;
		rep_out_d   = (state_d == ST_EXPIRED && rep_left_d == time_t'(1)) ? '0 : rep_left_d;
	end

	// timer state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= '0;
			repeats_q   <= '0;
			run_state_q <= ST_STOPPED;
			target_q    <= '0;
			saved_q     <= '0;
			rep_left_q  <= '0;
		end else begin
			if (step) begin
				run_state_q <= state_d;
				target_q    <= target_d;
				saved_q     <= saved_d;
				rep_left_q  <= rep_left_d;
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg_index_t'(cfg.index))
					CFG_INTERVAL: interval_q <= cfg.data;
					CFG_REPEATS: begin
						repeats_q  <= cfg.data;
						rep_left_q <= cfg.data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			fired_q      <= fired_d;
			state_out_q  <= state_d;
			time_left_q  <= time_left_d;
			rep_out_q    <= rep_out_d;
			target_out_q <= target_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.fired        = fired_q;
	assign rsp.timer_state  = state_out_q;
	assign rsp.time_left    = time_left_q;
	assign rsp.repeats_left = rep_out_q;
	assign rsp.target_time  = target_out_q;

endmodule

[hdl/rit_checker.sv]
// Port-level checks for the repeating interval timer, bound to the top level.
module rit_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_fired,
	input logic [rit_pkg::STATE_W-1:0] rsp_timer_state,
	input rit_pkg::time_t              rsp_time_left,
	input rit_pkg::time_t              rsp_repeats_left,
	input rit_pkg::time_t              rsp_target_time
);
	import rit_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_fired) && $stable(rsp_timer_state)
			&& $stable(rsp_time_left) && $stable(rsp_repeats_left)
			&& $stable(rsp_target_time))
		else $error("stalled result changed");

	// a firing check never leaves the timer stopped
	a_fired_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fired |-> rsp_timer_state != ST_STOPPED)
		else $error("fired with timer stopped");

	// firing into the expired state consumes the last repeat
	a_fired_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fired && rsp_timer_state == ST_EXPIRED |-> rsp_repeats_left == '0)
		else $error("expired with repeats left");

endmodule

bind repeating_interval_timer rit_checker u_rit_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_fired        (rsp.fired),
	.rsp_timer_state  (rsp.timer_state),
	.rsp_time_left    (rsp.time_left),
	.rsp_repeats_left (rsp.repeats_left),
	.rsp_target_time  (rsp.target_time)
);
